### src/assert_macros.svh
// Assertion macros shared by the verification checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define MBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in this cycle, consequent in the following cycle.
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `MBD_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### src/mbd_pkg.sv
// Types, register codes and pixel helper functions for the 2x2 mip downsampler.
package mbd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DST_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_DST_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

    // Pixel format codes (the unused code is handled as ARGB8888)
    localparam logic [1:0] FMT_ARGB8888 = 2'd0;
    localparam logic [1:0] FMT_A1R5G5B5 = 2'd1;
    localparam logic [1:0] FMT_R5G6B5   = 2'd2;

    // Fixed field widths
    localparam int DW_W           = 13;   // dst_width register
    localparam int DH_W           = 14;   // dst_height register
    localparam int ROW_W          = 14;   // source row counter
    localparam int Y_W            = 13;   // destination row
    localparam int OX_W           = 12;   // out_x port
    localparam int CFG_D_W        = 14;   // config write data
    localparam int MAX_DST_HEIGHT = 8192;

    // Four 9-bit channel sums {a, r, g, b}
    typedef logic [35:0] pair_sum_t;

    // Control carried alongside a word in the input stage
    typedef struct packed {
        logic           emit;   // odd column on an odd row: produces a result
        logic           last;   // final pixel of the level
        logic [Y_W-1:0] y;
    } s1_ctrl_t;

    // Expand a source pixel to ARGB8888
    function automatic logic [31:0] widen(input logic [31:0] p, input logic [1:0] fmt);
        logic [15:0] v;
        logic [31:0] r;
        begin
            v = p[15:0];
            case (fmt)
                FMT_A1R5G5B5: r = {{8{v[15]}}, v[14:10], 3'b000, v[9:5], 3'b000,
                                   v[4:0], 3'b000};
                FMT_R5G6B5:   r = {8'hFF, v[15:11], 3'b000, v[10:5], 2'b00,
                                   v[4:0], 3'b000};
                default:      r = p;
            endcase
            return r;
        end
    endfunction

    // Per-channel sum of two ARGB8888 pixels
    function automatic pair_sum_t pair_sum(input logic [31:0] p, input logic [31:0] q);
        pair_sum_t s;
        begin
            for (int ch = 0; ch < 4; ch++) begin
                s[9*ch +: 9] = {1'b0, p[8*ch +: 8]} + {1'b0, q[8*ch +: 8]};
            end
            return s;
        end
    endfunction

    // Add two rows of pair sums, divide by four, pack into the output format
    function automatic logic [31:0] avg_pack(input pair_sum_t prev, input pair_sum_t cur,
                                             input logic [1:0] fmt);
        logic [9:0]  s;
        logic [31:0] c;   // averaged ARGB8888
        logic [31:0] r;
        begin
            for (int ch = 0; ch < 4; ch++) begin
                s = {1'b0, prev[9*ch +: 9]} + {1'b0, cur[9*ch +: 9]};
                c[8*ch +: 8] = s[9:2];
            end
            case (fmt)
                FMT_A1R5G5B5: r = {16'h0000, c[31], c[23:19], c[15:11], c[7:3]};
                FMT_R5G6B5:   r = {16'h0000, c[23:19], c[15:10], c[7:3]};
                default:      r = c;
            endcase
            return r;
        end
    endfunction

endpackage

### src/mbd_linebuf.sv
// Line buffer of pair sums of one even source row, one entry per output column.
module mbd_linebuf
    import mbd_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  pair_sum_t     wdata,
    output pair_sum_t     rdata
);

    pair_sum_t mem [DEPTH];
    pair_sum_t rdata_reg;

    // Single port: even rows write, odd rows read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mbd_cfg_cnt.sv
// Configuration registers and source column/row position counters.
module mbd_cfg_cnt
    import mbd_pkg::*;
#(
    parameter int MAX_DST_WIDTH = 4096,
    parameter int XW            = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_D_W-1:0] cfg_data,
    input  logic               advance,
    output logic [1:0]         fmt,
    output logic               col_odd,
    output logic               row_odd,
    output logic [XW-1:0]      x,
    output logic [Y_W-1:0]     y,
    output logic               last
);

    localparam int EW = XW + 1;   // effective width, can hold MAX_DST_WIDTH
    localparam int CW = XW + 1;   // source column counter

    logic [DW_W-1:0]  dst_width_reg;
    logic [DH_W-1:0]  dst_height_reg;
    logic [1:0]       fmt_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [EW-1:0]    eff_w;
    logic [DH_W-1:0]  eff_h;
    logic [CW:0]      two_w;
    logic [ROW_W:0]   two_h;
    logic [CW:0]      col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             geom_wr;

    // Clamp geometry: zero counts as one, limits at the maximum sizes
    always_comb
    begin
        if (dst_width_reg == '0)
            eff_w = EW'(1);
        else if ({1'b0, dst_width_reg} > (DW_W+1)'(MAX_DST_WIDTH))
            eff_w = EW'(MAX_DST_WIDTH);
        else
            eff_w = EW'(dst_width_reg);

        if (dst_height_reg == '0)
            eff_h = DH_W'(1);
        else if (dst_height_reg > DH_W'(MAX_DST_HEIGHT))
            eff_h = DH_W'(MAX_DST_HEIGHT);
        else
            eff_h = dst_height_reg;
    end

    assign two_w    = {eff_w, 1'b0};
    assign two_h    = {eff_h, 1'b0};
    assign col_inc  = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign col_wrap = (col_inc >= two_w);
    assign row_wrap = (row_inc >= two_h);
    assign geom_wr  = cfg_wr && ((cfg_index == CFG_DST_WIDTH) ||
                                 (cfg_index == CFG_DST_HEIGHT));

    // Raster position after this word; a width or height write resets it
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_width_reg  <= DW_W'(1);
            dst_height_reg <= DH_W'(1);
            fmt_reg        <= FMT_ARGB8888;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_DST_WIDTH:    dst_width_reg  <= cfg_data[DW_W-1:0];
                    CFG_DST_HEIGHT:   dst_height_reg <= cfg_data[DH_W-1:0];
                    CFG_PIXEL_FORMAT: fmt_reg        <= cfg_data[1:0];
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign fmt     = fmt_reg;
    assign col_odd = col_reg[0];
    assign row_odd = row_reg[0];
    assign x       = col_reg[CW-1:1];
    assign y       = row_reg[ROW_W-1:1];
    // Both counters wrap only on the final source pixel
    assign last    = col_wrap && row_wrap;

endmodule

### src/mbd_out_stage.sv
// Output stage: combines the two rows of pair sums, averages, packs and holds the result.
module mbd_out_stage
    import mbd_pkg::*;
#(
    parameter int XW = 12
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pair_sum_t       prev,
    input  pair_sum_t       cur,
    input  logic [XW-1:0]   x,
    input  s1_ctrl_t        ctrl,
    input  logic [1:0]      fmt,
    input  logic            out_ready,
    output logic            free,
    output logic            out_valid,
    output logic [31:0]     out_pixel,
    output logic [OX_W-1:0] out_x,
    output logic [Y_W-1:0]  out_y,
    output logic            last_pixel
);

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     out_pixel_reg;
    logic [OX_W-1:0] out_x_reg;
    logic [Y_W-1:0]  out_y_reg;
    logic            last_reg;

    assign free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_pixel_reg <= avg_pack(prev, cur, fmt);
            out_x_reg     <= OX_W'(x);
            out_y_reg     <= ctrl.y;
            last_reg      <= ctrl.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign last_pixel = last_reg;

endmodule

### src/mipmap_box_downsample_2x2.sv
// Top level of the 2x2 box-filter mip level downsampler.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready  | source_pixel
//  out     | output    | out_valid/out_ready  | out_pixel, out_x, out_y, last_pixel
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One source word per clock is accepted unless an output stall holds in_ready low.
// The odd-row, odd-column word that completes a 2x2 block passes the input stage
// (line buffer read) and then the output register, where its result appears.
// The line buffer has one port; even rows write it, odd rows read it, and it needs
// no clearing. Reset clears counters and valid flags and presets config.
// A stalled output holds its word; the input stage keeps accepting until it too
// holds a word that cannot move, so in_ready drops only under an output stall.
module mipmap_box_downsample_2x2
    import mbd_pkg::*;
#(
    parameter int MAX_DST_WIDTH = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        source_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_pixel,
    output logic [OX_W-1:0]    out_x,
    output logic [Y_W-1:0]     out_y,
    output logic               last_pixel,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_D_W-1:0] cfg_data
);

    localparam int XW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;

    logic          accept;
    logic          cfg_wr;
    logic [1:0]    fmt;
    logic          col_odd;
    logic          row_odd;
    logic [XW-1:0] x;
    logic [Y_W-1:0] y;
    logic          last;
    logic [31:0]   px;
    pair_sum_t     cur_sum;
    pair_sum_t     prev_sum;
    logic          lb_we;
    logic          lb_re;

    logic [31:0]   pair_hold_reg;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    pair_sum_t     s1_sum_reg;
    logic [XW-1:0] s1_x_reg;
    s1_ctrl_t      s1_ctrl_reg;
    logic          s1_adv;
    logic          out_load;
    logic          out_free;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign accept    = in_valid && in_ready;

    // Config registers and raster position
    mbd_cfg_cnt #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH),
        .XW            (XW)
    ) u_cfg_cnt (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .fmt       (fmt),
        .col_odd   (col_odd),
        .row_odd   (row_odd),
        .x         (x),
        .y         (y),
        .last      (last)
    );

    // Widen and sum the horizontal pair
    assign px      = widen(source_pixel, fmt);
    assign cur_sum = pair_sum(pair_hold_reg, px);
    assign lb_we   = accept && col_odd && !row_odd;
    assign lb_re   = accept && col_odd && row_odd;

    mbd_linebuf #(
        .DEPTH (MAX_DST_WIDTH),
        .AW    (XW)
    ) u_linebuf (
        .clk   (clk),
        .we    (lb_we),
        .re    (lb_re),
        .addr  (x),
        .wdata (cur_sum),
        .rdata (prev_sum)
    );

    // Input stage flow control
    assign out_load = s1_valid_reg && s1_ctrl_reg.emit && out_free;
    assign s1_adv   = s1_valid_reg && (!s1_ctrl_reg.emit || out_free);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pair_hold_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept && !col_odd)
                pair_hold_reg <= px;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg       <= cur_sum;
            s1_x_reg         <= x;
            s1_ctrl_reg.emit <= col_odd && row_odd;
            s1_ctrl_reg.last <= last;
            s1_ctrl_reg.y    <= y;
        end
    end

    mbd_out_stage #(
        .XW (XW)
    ) u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .prev       (prev_sum),
        .cur        (s1_sum_reg),
        .x          (s1_x_reg),
        .ctrl       (s1_ctrl_reg),
        .fmt        (fmt),
        .out_ready  (out_ready),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_pixel  (out_pixel),
        .out_x      (out_x),
        .out_y      (out_y),
        .last_pixel (last_pixel)
    );

endmodule

### src/mbd_checker.sv
// Port-level checker for the downsampler, bound to the top level.
`include "assert_macros.svh"

module mbd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pixel,
    input logic [11:0] out_x,
    input logic [12:0] out_y,
    input logic        last_pixel
);

    // A stalled result word holds
    `MBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(out_x) && $stable(out_y) && $stable(last_pixel), "out word changed while stalled")

    // Input backpressure only comes from a stalled output
    `MBD_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "in_ready low without output stall")

    // A fresh result traces back to an accepted word through the input stage and output registers
    `MBD_ASSERT(a_out_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without matching input word")

endmodule

bind mipmap_box_downsample_2x2 mbd_checker u_mbd_checker (.*);
